// ===== design/dead_reckoning_pose_update_macros.svh =====
// Assertion macros shared by the pose update block.
// Depends on nothing; included by the top level.
`ifndef DEAD_RECKONING_POSE_UPDATE_MACROS_SVH
`define DEAD_RECKONING_POSE_UPDATE_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define DRPU_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define DRPU_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== design/drpu_pkg.sv =====
// Shared widths, constants, unit request types and the arctangent table
// for the pose update block. No dependencies.
package drpu_pkg;

  localparam int ANGLE_ITERATIONS = 16;
  localparam int TAB_IDX_W        = 5;

  localparam int CW      = 64;  // CORDIC x/y datapath
  localparam int ZW      = 32;  // angle, 2^-24 rad
  localparam int TRIG_W  = 28;  // Q24 sine and cosine
  localparam int MUL_A_W = 40;
  localparam int MUL_B_W = 32;
  localparam int PROD_W  = 64;
  localparam int DIV_N_W = 64;
  localparam int DIV_D_W = 32;
  localparam int LIN_W   = 40;
  localparam int DELTA_W = 64;
  localparam int POS_W   = 32;
  localparam int HEAD_W  = 16;
  localparam int Q_W     = 16;
  localparam int ELAP_W  = 24;
  localparam int MIN_W   = 20;
  localparam int THR_W   = 15;

  localparam int IN_DATA_W  = 216;
  localparam int OUT_DATA_W = 176;

  localparam logic signed [ZW-1:0]     ANG_PI      = 32'sd52707179;
  localparam logic signed [ZW-1:0]     ANG_HALF_PI = 32'sd26353589;
  localparam logic signed [CW-1:0]     CORDIC_K30  = 64'sd652032874;
  localparam logic signed [HEAD_W-1:0] HEADING_MAX = 16'sd25736;

  localparam logic [MIN_W-1:0]   MIN_INTERVAL_RST = 20'd1000;
  localparam logic [THR_W-1:0]   STRAIGHT_THR_RST = 15'd82;
  localparam logic [DIV_D_W-1:0] US_PER_S         = 32'd1000000;
  localparam logic [DIV_N_W-1:0] US_PER_S_HALF    = 64'd500000;

  localparam logic CORDIC_ROT = 1'b0;
  localparam logic CORDIC_VEC = 1'b1;

  typedef struct packed {
    logic                 start;
    logic                 vec;
    logic signed [CW-1:0] x;
    logic signed [CW-1:0] y;
    logic signed [ZW-1:0] theta;
  } cordic_req_t;

  typedef struct packed {
    logic                      start;
    logic signed [MUL_A_W-1:0] a;
    logic signed [MUL_B_W-1:0] b;
  } mul_req_t;

  typedef struct packed {
    logic               start;
    logic [DIV_N_W-1:0] num;
    logic [DIV_D_W-1:0] den;
  } div_req_t;

  // atan(2^-i) in 2^-24 rad.
  function automatic logic signed [ZW-1:0] atan_entry(input logic [TAB_IDX_W-1:0] idx);
    logic signed [ZW-1:0] v;
    unique case (idx)
      5'd0:    v = 32'sd13176795;
      5'd1:    v = 32'sd7778716;
      5'd2:    v = 32'sd4110060;
      5'd3:    v = 32'sd2086331;
      5'd4:    v = 32'sd1047214;
      5'd5:    v = 32'sd524117;
      5'd6:    v = 32'sd262123;
      5'd7:    v = 32'sd131069;
      5'd8:    v = 32'sd65536;
      5'd9:    v = 32'sd32768;
      5'd10:   v = 32'sd16384;
      5'd11:   v = 32'sd8192;
      5'd12:   v = 32'sd4096;
      5'd13:   v = 32'sd2048;
      5'd14:   v = 32'sd1024;
      5'd15:   v = 32'sd512;
      5'd16:   v = 32'sd256;
      5'd17:   v = 32'sd128;
      5'd18:   v = 32'sd64;
      5'd19:   v = 32'sd32;
      5'd20:   v = 32'sd16;
      5'd21:   v = 32'sd8;
      5'd22:   v = 32'sd4;
      5'd23:   v = 32'sd2;
      default: v = 32'sd0;
    endcase
    return v;
  endfunction

endpackage

// ===== design/drpu_mul.sv =====
// Serial signed multiplier, four bits of the second operand per cycle.
// Depends on drpu_pkg.
module drpu_mul (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  drpu_pkg::mul_req_t                     req,
  output logic                                   done,
  output logic signed [drpu_pkg::PROD_W-1:0]     prod
);

  localparam int STEPS = drpu_pkg::MUL_B_W / 4;
  localparam int CNT_W = $clog2(STEPS);

  logic [drpu_pkg::PROD_W-1:0]  a_r;
  logic [drpu_pkg::MUL_B_W-1:0] b_r;
  logic [drpu_pkg::PROD_W-1:0]  acc_r;
  logic [drpu_pkg::PROD_W-1:0]  acc_nxt;
  logic [CNT_W-1:0]             cnt_r;
  logic                         neg_r;
  logic                         busy_r;
  logic                         done_r;
  logic [drpu_pkg::MUL_A_W-1:0] a_mag;
  logic [drpu_pkg::MUL_B_W-1:0] b_mag;

  assign a_mag = req.a[drpu_pkg::MUL_A_W-1] ? drpu_pkg::MUL_A_W'(-req.a)
                                            : drpu_pkg::MUL_A_W'(req.a);
  assign b_mag = req.b[drpu_pkg::MUL_B_W-1] ? drpu_pkg::MUL_B_W'(-req.b)
                                            : drpu_pkg::MUL_B_W'(req.b);
  assign acc_nxt = acc_r + a_r * drpu_pkg::PROD_W'(b_r[3:0]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        a_r    <= drpu_pkg::PROD_W'(a_mag);
        b_r    <= b_mag;
        acc_r  <= '0;
        neg_r  <= req.a[drpu_pkg::MUL_A_W-1] ^ req.b[drpu_pkg::MUL_B_W-1];
        cnt_r  <= '0;
        busy_r <= 1'b1;
      end else if (busy_r) begin
        acc_r <= acc_nxt;
        a_r   <= a_r << 4;
        b_r   <= b_r >> 4;
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == CNT_W'(STEPS - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign done = done_r;
  assign prod = neg_r ? -$signed(acc_r) : $signed(acc_r);

endmodule

// ===== design/drpu_div.sv =====
// Restoring unsigned divider, one quotient bit per cycle.
// Depends on drpu_pkg.
module drpu_div (
  input  logic                         clk,
  input  logic                         rst_n,
  input  drpu_pkg::div_req_t           req,
  output logic                         done,
  output logic [drpu_pkg::DIV_N_W-1:0] quot
);

  localparam int CNT_W = $clog2(drpu_pkg::DIV_N_W);

  logic [drpu_pkg::DIV_N_W-1:0] n_r;
  logic [drpu_pkg::DIV_D_W-1:0] den_r;
  logic [drpu_pkg::DIV_D_W-1:0] rem_r;
  logic [drpu_pkg::DIV_D_W:0]   rem_sh;
  logic [drpu_pkg::DIV_D_W:0]   rem_sub;
  logic                         fits;
  logic [CNT_W-1:0]             cnt_r;
  logic                         busy_r;
  logic                         done_r;

  assign rem_sh  = {rem_r, n_r[drpu_pkg::DIV_N_W-1]};
  assign rem_sub = rem_sh - {1'b0, den_r};
  assign fits    = rem_sh >= {1'b0, den_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        n_r    <= req.num;
        den_r  <= req.den;
        rem_r  <= '0;
        cnt_r  <= '0;
        busy_r <= 1'b1;
      end else if (busy_r) begin
        rem_r <= fits ? rem_sub[drpu_pkg::DIV_D_W-1:0] : rem_sh[drpu_pkg::DIV_D_W-1:0];
        n_r   <= {n_r[drpu_pkg::DIV_N_W-2:0], fits};
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == CNT_W'(drpu_pkg::DIV_N_W - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign done = done_r;
  assign quot = n_r;

endmodule

// ===== design/drpu_cordic.sv =====
// Iterative CORDIC, one micro-rotation per cycle, in vectoring mode
// (atan2) or rotation mode (Q24 cosine and sine). Depends on drpu_pkg.
module drpu_cordic #(
  parameter int ITER = drpu_pkg::ANGLE_ITERATIONS
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  drpu_pkg::cordic_req_t               req,
  output logic                                done,
  output logic signed [drpu_pkg::ZW-1:0]      z_o,
  output logic signed [drpu_pkg::TRIG_W-1:0]  cos_o,
  output logic signed [drpu_pkg::TRIG_W-1:0]  sin_o
);

  localparam int CNT_W = $clog2(ITER);

  logic signed [drpu_pkg::CW-1:0] x_r, y_r, xs, ys, xf, yf;
  logic signed [drpu_pkg::ZW-1:0] z_r, t;
  logic [CNT_W-1:0]               i_r;
  logic                           vec_r, neg_r, busy_r, done_r, cw;

  assign xs = x_r >>> i_r;
  assign ys = y_r >>> i_r;
  assign t  = drpu_pkg::atan_entry(drpu_pkg::TAB_IDX_W'(i_r));
  assign cw = vec_r ? (y_r > 0) : (z_r < 0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      i_r    <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        vec_r  <= req.vec;
        i_r    <= '0;
        busy_r <= 1'b1;
        neg_r  <= 1'b0;
        if (req.vec == drpu_pkg::CORDIC_VEC) begin
          // Left half plane: pre-rotate by pi so the iterations converge.
          if (req.x < 0) begin
            x_r <= -req.x;
            y_r <= -req.y;
            z_r <= (req.y >= 0) ? drpu_pkg::ANG_PI : -drpu_pkg::ANG_PI;
          end else begin
            x_r <= req.x;
            y_r <= req.y;
            z_r <= '0;
          end
        end else begin
          x_r <= drpu_pkg::CORDIC_K30;
          y_r <= '0;
          if (req.theta > drpu_pkg::ANG_HALF_PI) begin
            z_r   <= req.theta - drpu_pkg::ANG_PI;
            neg_r <= 1'b1;
          end else if (req.theta < -drpu_pkg::ANG_HALF_PI) begin
            z_r   <= req.theta + drpu_pkg::ANG_PI;
            neg_r <= 1'b1;
          end else begin
            z_r <= req.theta;
          end
        end
      end else if (busy_r) begin
        if (cw) begin
          x_r <= x_r + ys;
          y_r <= y_r - xs;
          z_r <= z_r + t;
        end else begin
          x_r <= x_r - ys;
          y_r <= y_r + xs;
          z_r <= z_r - t;
        end
        i_r <= i_r + 1'b1;
        if (i_r == CNT_W'(ITER - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign xf    = (neg_r ? -x_r : x_r) + 64'sd32;
  assign yf    = (neg_r ? -y_r : y_r) + 64'sd32;
  assign done  = done_r;
  assign z_o   = z_r;
  assign cos_o = drpu_pkg::TRIG_W'(xf >>> 6);
  assign sin_o = drpu_pkg::TRIG_W'(yf >>> 6);

endmodule

// ===== design/dead_reckoning_pose_update.sv =====
// Dead-reckoning pose update: top level with sequencer, state and ports.
// Depends on drpu_pkg, drpu_mul, drpu_div, drpu_cordic and the macro header.
//
// One input transaction per odometry tick on in_* (tuser = messages ready).
// The block takes yaw from the quaternion, then, once seeded and when the
// interval is long enough, advances the planar pose along a chord or an arc
// and offers one result transaction on out_*. Ticks that only seed the pose
// or fall below the minimum interval produce no result.
// All arithmetic runs on one serial multiplier (4 bits per cycle), one
// restoring divider (1 bit per cycle) and one CORDIC (one step per cycle)
// under a single sequencer, so in_tready is high only while idle.
// A seeding or skipped tick is the shortest, a chord update takes longer
// and an arc update, with a second CORDIC run and two more divisions, longest;
// the divider's 64 steps and the eight quaternion products dominate.
// The result sits in an output register: a stalled receiver holds it and
// the next tick is still computed, waiting only for that register to free.
// Synchronous active-low reset clears the pose, heading and seeded flag and
// restores the register defaults (min_interval_us 1000, threshold 82).
// Registers via APB: min_interval_us at 0x0, straight_threshold at 0x4.
`include "dead_reckoning_pose_update_macros.svh"

module dead_reckoning_pose_update #(
  parameter int ANGLE_ITERATIONS = drpu_pkg::ANGLE_ITERATIONS
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_tvalid,
  output logic                               in_tready,
  // forward_speed, elapsed_us, orient_qx, orient_qy, orient_qz, orient_qw,
  // wheel_pos_x, wheel_pos_y, wheel_pos_z
  input  logic [drpu_pkg::IN_DATA_W-1:0]     in_tdata,
  // msgs_ready
  input  logic                               in_tuser,
  output logic                               out_tvalid,
  input  logic                               out_tready,
  // pose_x, pose_y, pose_z, out_qx, out_qy, out_qz, out_qw, heading
  output logic [drpu_pkg::OUT_DATA_W-1:0]    out_tdata,
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [2:0]                         paddr,
  input  logic [31:0]                        pwdata,
  output logic [31:0]                        prdata,
  output logic                               pready
);

  localparam logic REG_MIN_INTERVAL = 1'b0;
  localparam logic REG_STRAIGHT_THR = 1'b1;

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_QMUL = 4'd1;
  localparam logic [3:0] S_YAW  = 4'd2;
  localparam logic [3:0] S_YAWW = 4'd3;
  localparam logic [3:0] S_DEC  = 4'd4;
  localparam logic [3:0] S_LMUL = 4'd5;
  localparam logic [3:0] S_LDIV = 4'd6;
  localparam logic [3:0] S_BR   = 4'd7;
  localparam logic [3:0] S_CRD0 = 4'd8;
  localparam logic [3:0] S_CRD1 = 4'd9;
  localparam logic [3:0] S_XMUL = 4'd10;
  localparam logic [3:0] S_XDIV = 4'd11;
  localparam logic [3:0] S_YMUL = 4'd12;
  localparam logic [3:0] S_YDIV = 4'd13;
  localparam logic [3:0] S_EMIT = 4'd14;

  function automatic logic signed [drpu_pkg::POS_W-1:0] sat_pos(
    input logic signed [drpu_pkg::DELTA_W:0] v);
    logic signed [drpu_pkg::POS_W-1:0] r;
    if (v > (drpu_pkg::DELTA_W+1)'(32'sh7fffffff)) r = 32'sh7fffffff;
    else if (v < (drpu_pkg::DELTA_W+1)'(-33'sh80000000)) r = 32'sh80000000;
    else r = drpu_pkg::POS_W'(v);
    return r;
  endfunction

  // Configuration
  logic [drpu_pkg::MIN_W-1:0] min_interval_r;
  logic [drpu_pkg::THR_W-1:0] straight_thr_r;
  logic                       cfg_wr;

  // Sequencer and captured tick
  logic [3:0] st_r;
  logic       pend_r;
  logic [2:0] mi_r;
  logic       ready_r;
  logic signed [31:0]               speed_r;
  logic [drpu_pkg::ELAP_W-1:0]      elapsed_r;
  logic signed [drpu_pkg::Q_W-1:0]  qx_r, qy_r, qz_r, qw_r;
  logic signed [drpu_pkg::POS_W-1:0] wx_r, wy_r, wz_r;

  // Working values
  logic signed [31:0]                  prod_r [8];
  logic signed [drpu_pkg::HEAD_W-1:0]  yaw_r;
  logic signed [drpu_pkg::PROD_W-1:0]  p_r;
  logic signed [drpu_pkg::LIN_W-1:0]   lin_r;
  logic signed [16:0]                  a_r;
  logic                                chord_r;
  logic signed [drpu_pkg::TRIG_W-1:0]  c_r, s_r, c0_r, s0_r;
  logic signed [drpu_pkg::DELTA_W-1:0] dx_r, dy_r;

  // Pose state and output register
  logic                                seeded_r;
  logic signed [drpu_pkg::POS_W-1:0]   last_x_r, last_y_r;
  logic signed [drpu_pkg::HEAD_W-1:0]  last_h_r;
  logic                                out_tvalid_r;
  logic [drpu_pkg::OUT_DATA_W-1:0]     out_data_r;

  // Unit interfaces
  drpu_pkg::mul_req_t    mul_req;
  drpu_pkg::div_req_t    div_req;
  drpu_pkg::cordic_req_t cordic_req;
  logic                                mul_done, div_done, cordic_done;
  logic signed [drpu_pkg::PROD_W-1:0]  mul_prod;
  logic [drpu_pkg::DIV_N_W-1:0]        div_quot;
  logic signed [drpu_pkg::ZW-1:0]      cordic_z;
  logic signed [drpu_pkg::TRIG_W-1:0]  cordic_cos, cordic_sin;

  // Combinational helpers
  logic signed [drpu_pkg::Q_W-1:0]     qa, qb;
  logic signed [33:0]                  d_c, s_c, sabs_c, x_c, y_c;
  logic                                skip_yaw;
  logic [drpu_pkg::ZW-1:0]             zmag;
  logic [drpu_pkg::ZW-1:0]             hmag;
  logic [drpu_pkg::HEAD_W-1:0]         hclamp;
  logic signed [drpu_pkg::HEAD_W-1:0]  yaw_c;
  logic signed [16:0]                  a_c;
  logic [16:0]                         amag_c, amag;
  logic [drpu_pkg::PROD_W-1:0]         pmag, mpmag, r24;
  logic signed [drpu_pkg::DELTA_W-1:0] rnd24;
  logic                                div_neg;
  logic signed [drpu_pkg::DELTA_W-1:0] div_qs;
  logic signed [drpu_pkg::POS_W-1:0]   nx_c, ny_c;
  logic                                out_load;

  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite & pready;

  always_comb begin
    unique case (paddr[2])
      REG_MIN_INTERVAL: prdata = 32'(min_interval_r);
      REG_STRAIGHT_THR: prdata = 32'(straight_thr_r);
    endcase
  end

  // Quaternion product operands.
  always_comb begin
    unique case (mi_r)
      3'd0: begin qa = qx_r; qb = qx_r; end
      3'd1: begin qa = qy_r; qb = qy_r; end
      3'd2: begin qa = qz_r; qb = qz_r; end
      3'd3: begin qa = qw_r; qb = qw_r; end
      3'd4: begin qa = qx_r; qb = qz_r; end
      3'd5: begin qa = qw_r; qb = qy_r; end
      3'd6: begin qa = qx_r; qb = qy_r; end
      3'd7: begin qa = qw_r; qb = qz_r; end
    endcase
  end

  // Yaw terms from the squared and cross products. The sine of pitch test
  // compares against the norm, so the quaternion need not be unit length.
  assign d_c    = 34'(prod_r[0]) + 34'(prod_r[1]) + 34'(prod_r[2]) + 34'(prod_r[3]);
  assign s_c    = (34'(prod_r[4]) - 34'(prod_r[5])) <<< 1;
  assign sabs_c = (s_c < 0) ? -s_c : s_c;
  assign x_c    = 34'(prod_r[0]) + 34'(prod_r[3]) - 34'(prod_r[1]) - 34'(prod_r[2]);
  assign y_c    = (34'(prod_r[6]) + 34'(prod_r[7])) <<< 1;
  assign skip_yaw = (sabs_c >= d_c) || (x_c == 0 && y_c == 0);

  // Round the CORDIC angle half away from zero to 2^-13 rad and clamp.
  assign zmag   = (cordic_z < 0) ? drpu_pkg::ZW'(-cordic_z) : drpu_pkg::ZW'(cordic_z);
  assign hmag   = (zmag + 32'd1024) >> 11;
  assign hclamp = (hmag > 32'(drpu_pkg::HEADING_MAX)) ? drpu_pkg::HEADING_MAX
                                                     : drpu_pkg::HEAD_W'(hmag);
  assign yaw_c  = (cordic_z < 0) ? -$signed(hclamp) : $signed(hclamp);

  assign a_c    = 17'(yaw_r) - 17'(last_h_r);
  assign amag_c = (a_c < 0) ? 17'(-a_c) : 17'(a_c);
  assign amag   = (a_r < 0) ? 17'(-a_r) : 17'(a_r);

  assign pmag  = (p_r < 0) ? drpu_pkg::PROD_W'(-p_r) : drpu_pkg::PROD_W'(p_r);
  assign mpmag = (mul_prod < 0) ? drpu_pkg::PROD_W'(-mul_prod) : drpu_pkg::PROD_W'(mul_prod);
  assign r24   = (mpmag + 64'd8388608) >> 24;
  assign rnd24 = (mul_prod < 0) ? -$signed(r24) : $signed(r24);

  assign div_neg = p_r[drpu_pkg::PROD_W-1] ^ ((st_r != S_LDIV) & a_r[16]);
  assign div_qs  = div_neg ? -$signed(div_quot) : $signed(div_quot);

  // Shared unit requests
  always_comb begin
    mul_req.start = !pend_r && (st_r == S_QMUL || st_r == S_LMUL ||
                                st_r == S_XMUL || st_r == S_YMUL);
    if (st_r == S_QMUL) begin
      mul_req.a = drpu_pkg::MUL_A_W'(qa);
      mul_req.b = drpu_pkg::MUL_B_W'(qb);
    end else if (st_r == S_LMUL) begin
      mul_req.a = drpu_pkg::MUL_A_W'(speed_r);
      mul_req.b = drpu_pkg::MUL_B_W'(elapsed_r);
    end else if (st_r == S_XMUL) begin
      mul_req.a = lin_r;
      mul_req.b = chord_r ? drpu_pkg::MUL_B_W'(c_r)
                          : drpu_pkg::MUL_B_W'(s_r) - drpu_pkg::MUL_B_W'(s0_r);
    end else begin
      mul_req.a = lin_r;
      mul_req.b = chord_r ? drpu_pkg::MUL_B_W'(s_r)
                          : drpu_pkg::MUL_B_W'(c_r) - drpu_pkg::MUL_B_W'(c0_r);
    end

    div_req.start = !pend_r && (st_r == S_LDIV || st_r == S_XDIV || st_r == S_YDIV);
    if (st_r == S_LDIV) begin
      div_req.num = pmag + drpu_pkg::US_PER_S_HALF;
      div_req.den = drpu_pkg::US_PER_S;
    end else begin
      div_req.num = pmag + (drpu_pkg::DIV_N_W'(amag) << 10);
      div_req.den = drpu_pkg::DIV_D_W'(amag) << 11;
    end

    cordic_req.start = !pend_r && (st_r == S_YAWW || st_r == S_CRD0 || st_r == S_CRD1);
    cordic_req.vec   = (st_r == S_YAWW) ? drpu_pkg::CORDIC_VEC : drpu_pkg::CORDIC_ROT;
    cordic_req.x     = drpu_pkg::CW'(x_c) <<< 20;
    cordic_req.y     = drpu_pkg::CW'(y_c) <<< 20;
    if (st_r == S_CRD0 && chord_r) begin
      cordic_req.theta = (drpu_pkg::ZW'(last_h_r) <<< 11) + (drpu_pkg::ZW'(a_r) <<< 10);
    end else if (st_r == S_CRD0) begin
      cordic_req.theta = drpu_pkg::ZW'(yaw_r) <<< 11;
    end else begin
      cordic_req.theta = drpu_pkg::ZW'(last_h_r) <<< 11;
    end
  end

  assign nx_c     = sat_pos((drpu_pkg::DELTA_W+1)'(last_x_r) + (drpu_pkg::DELTA_W+1)'(dx_r));
  assign ny_c     = sat_pos((drpu_pkg::DELTA_W+1)'(last_y_r) + (drpu_pkg::DELTA_W+1)'(dy_r));
  assign out_load = (st_r == S_EMIT) && (!out_tvalid_r || out_tready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r           <= S_IDLE;
      pend_r         <= 1'b0;
      mi_r           <= '0;
      seeded_r       <= 1'b0;
      last_x_r       <= '0;
      last_y_r       <= '0;
      last_h_r       <= '0;
      out_tvalid_r   <= 1'b0;
      min_interval_r <= drpu_pkg::MIN_INTERVAL_RST;
      straight_thr_r <= drpu_pkg::STRAIGHT_THR_RST;
    end else begin
      if (cfg_wr) begin
        unique case (paddr[2])
          REG_MIN_INTERVAL: min_interval_r <= pwdata[drpu_pkg::MIN_W-1:0];
          REG_STRAIGHT_THR: straight_thr_r <= pwdata[drpu_pkg::THR_W-1:0];
        endcase
      end

      if (out_tvalid_r && out_tready) out_tvalid_r <= 1'b0;
      if (mul_req.start || div_req.start || cordic_req.start) pend_r <= 1'b1;

      unique case (st_r)
        S_IDLE: begin
          if (in_tvalid) begin
            ready_r   <= in_tuser;
            speed_r   <= in_tdata[31:0];
            elapsed_r <= in_tdata[55:32];
            qx_r      <= in_tdata[71:56];
            qy_r      <= in_tdata[87:72];
            qz_r      <= in_tdata[103:88];
            qw_r      <= in_tdata[119:104];
            wx_r      <= in_tdata[151:120];
            wy_r      <= in_tdata[183:152];
            wz_r      <= in_tdata[215:184];
            mi_r      <= '0;
            st_r      <= S_QMUL;
          end
        end
        S_QMUL: begin
          if (mul_done) begin
            pend_r       <= 1'b0;
            prod_r[mi_r] <= mul_prod[31:0];
            if (mi_r == 3'd7) st_r <= S_YAW;
            else mi_r <= mi_r + 1'b1;
          end
        end
        S_YAW: begin
          if (skip_yaw) begin
            yaw_r <= '0;
            st_r  <= S_DEC;
          end else begin
            st_r <= S_YAWW;
          end
        end
        S_YAWW: begin
          if (cordic_done) begin
            pend_r <= 1'b0;
            yaw_r  <= yaw_c;
            st_r   <= S_DEC;
          end
        end
        S_DEC: begin
          if (!ready_r || !seeded_r) begin
            last_x_r <= wx_r;
            last_y_r <= wy_r;
            last_h_r <= yaw_r;
            seeded_r <= ready_r;
            st_r     <= S_IDLE;
          end else if (elapsed_r < drpu_pkg::ELAP_W'(min_interval_r)) begin
            st_r <= S_IDLE;
          end else begin
            st_r <= S_LMUL;
          end
        end
        S_LMUL: begin
          if (mul_done) begin
            pend_r <= 1'b0;
            p_r    <= mul_prod;
            st_r   <= S_LDIV;
          end
        end
        S_LDIV: begin
          if (div_done) begin
            pend_r <= 1'b0;
            lin_r  <= drpu_pkg::LIN_W'(div_qs);
            st_r   <= S_BR;
          end
        end
        S_BR: begin
          a_r     <= a_c;
          // A zero turn always takes the chord, whatever the threshold.
          chord_r <= (a_c == 0) || (amag_c < 17'(straight_thr_r));
          st_r    <= S_CRD0;
        end
        S_CRD0: begin
          if (cordic_done) begin
            pend_r <= 1'b0;
            c_r    <= cordic_cos;
            s_r    <= cordic_sin;
            st_r   <= chord_r ? S_XMUL : S_CRD1;
          end
        end
        S_CRD1: begin
          if (cordic_done) begin
            pend_r <= 1'b0;
            c0_r   <= cordic_cos;
            s0_r   <= cordic_sin;
            st_r   <= S_XMUL;
          end
        end
        S_XMUL: begin
          if (mul_done) begin
            pend_r <= 1'b0;
            p_r    <= mul_prod;
            if (chord_r) begin
              dx_r <= rnd24;
              st_r <= S_YMUL;
            end else begin
              st_r <= S_XDIV;
            end
          end
        end
        S_XDIV: begin
          if (div_done) begin
            pend_r <= 1'b0;
            dx_r   <= div_qs;
            st_r   <= S_YMUL;
          end
        end
        S_YMUL: begin
          if (mul_done) begin
            pend_r <= 1'b0;
            p_r    <= mul_prod;
            if (chord_r) begin
              dy_r <= rnd24;
              st_r <= S_EMIT;
            end else begin
              st_r <= S_YDIV;
            end
          end
        end
        S_YDIV: begin
          if (div_done) begin
            pend_r <= 1'b0;
            dy_r   <= -div_qs;
            st_r   <= S_EMIT;
          end
        end
        S_EMIT: begin
          if (out_load) begin
            out_tvalid_r <= 1'b1;
            out_data_r   <= {yaw_r, qw_r, qz_r, qy_r, qx_r, wz_r, ny_c, nx_c};
            last_x_r     <= nx_c;
            last_y_r     <= ny_c;
            last_h_r     <= yaw_r;
            st_r         <= S_IDLE;
          end
        end
        default: st_r <= S_IDLE;
      endcase
    end
  end

  assign in_tready  = (st_r == S_IDLE);
  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_data_r;

  drpu_mul u_mul (
    .clk  (clk),
    .rst_n(rst_n),
    .req  (mul_req),
    .done (mul_done),
    .prod (mul_prod)
  );

  drpu_div u_div (
    .clk  (clk),
    .rst_n(rst_n),
    .req  (div_req),
    .done (div_done),
    .quot (div_quot)
  );

  drpu_cordic #(
    .ITER(ANGLE_ITERATIONS)
  ) u_cordic (
    .clk  (clk),
    .rst_n(rst_n),
    .req  (cordic_req),
    .done (cordic_done),
    .z_o  (cordic_z),
    .cos_o(cordic_cos),
    .sin_o(cordic_sin)
  );

  `DRPU_ASSERT_NOW(a_emit_src, clk, rst_n, $rose(out_tvalid_r), $past(st_r) == S_EMIT, "result loaded outside emit state")
  `DRPU_ASSERT_NOW(a_mul_owner, clk, rst_n, mul_done, pend_r && (st_r == S_QMUL || st_r == S_LMUL || st_r == S_XMUL || st_r == S_YMUL), "multiplier finished with no owner")
  `DRPU_ASSERT_NOW(a_heading_rng, clk, rst_n, out_tvalid_r, $signed(out_data_r[175:160]) <= drpu_pkg::HEADING_MAX && $signed(out_data_r[175:160]) >= -drpu_pkg::HEADING_MAX, "heading out of range")
  `DRPU_ASSERT_NEXT(a_unseed, clk, rst_n, st_r == S_DEC && !ready_r, !seeded_r, "seeded flag kept without messages")

endmodule
